// File: src/rational_arith_reduce_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Shared helpers for writing concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/rar_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Action codes and the result width RES_BITS for the front and the back.
// ----------------------------------------------------------------------------
package rar_pkg;
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_RED = 3'd4;
	localparam int RES_BITS = 33;
endpackage

// File: src/rar_gcd_div.sv
// ----------------------------------------------------------------------------
// Fraction reducer
// Replaces a zero denominator by 1, finds the GCD of the magnitudes by a
// restoring shift-subtract remainder, then divides both parts by it.
// One quotient or remainder bit per cycle.
// ----------------------------------------------------------------------------
module rar_gcd_div
	import rar_pkg::*;
#(
	parameter int W = 33
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                done,
	output logic signed [W-1:0] q_num,
	output logic signed [W-1:0] q_den,
	output logic                zflag
);
	localparam int CW = $clog2(W + 1);
	typedef enum logic [2:0] {S_IDLE, S_GCD_CHK, S_REM, S_DIVN, S_DIVD, S_DONE} state_t;
	state_t state_q;
	logic [W-1:0] x_q, y_q, g_q, rem_q, quo_q, dvd_q, nmag_q, dmag_q;
	logic [CW-1:0] cnt_q;
	logic nneg_q, dneg_q;
	logic [W:0] trial;
	logic [W-1:0] n_abs, d_abs;

	assign n_abs = num[W-1] ? W'(-num) : num;
	assign d_abs = (den == '0) ? W'(1) : (den[W-1] ? W'(-den) : den);
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, (state_q == S_REM) ? y_q : g_q};
	assign done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			zflag <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q <= n_abs;
						y_q <= d_abs;
						nmag_q <= n_abs;
						dmag_q <= d_abs;
						nneg_q <= num[W-1];
						dneg_q <= (den == '0) ? 1'b0 : den[W-1];
						zflag <= (den == '0);
						state_q <= S_GCD_CHK;
					end
				end
				S_GCD_CHK: begin
					if (y_q == '0) begin
						g_q <= (x_q == '0) ? W'(1) : x_q;
						dvd_q <= nmag_q;
						rem_q <= '0;
						cnt_q <= CW'(W);
						state_q <= S_DIVN;
					end else begin
						dvd_q <= x_q;
						rem_q <= '0;
						cnt_q <= CW'(W);
						state_q <= S_REM;
					end
				end
				S_REM, S_DIVN, S_DIVD: begin
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						if (state_q == S_REM) begin
							x_q <= y_q;
							y_q <= trial[W] ? {rem_q[W-2:0], dvd_q[W-1]} : trial[W-1:0];
							state_q <= S_GCD_CHK;
						end else if (state_q == S_DIVN) begin
							q_num <= nneg_q ? W'(-{quo_q[W-2:0], ~trial[W]})
								: {quo_q[W-2:0], ~trial[W]};
							dvd_q <= dmag_q;
							rem_q <= '0;
							cnt_q <= CW'(W);
							state_q <= S_DIVD;
						end else begin
							q_den <= dneg_q ? W'(-{quo_q[W-2:0], ~trial[W]})
								: {quo_q[W-2:0], ~trial[W]};
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/rar_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts items and sign-extends operands into a two-entry queue.
// ----------------------------------------------------------------------------
module rar_front
	import rar_pkg::*;
#(
	parameter int OPERAND_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [2:0]  action,
	input  logic signed [15:0] a_num, a_den, b_num, b_den,
	output logic        q_valid,
	input  logic        q_pop,
	output logic [2:0]  q_act,
	output logic signed [15:0] q_an, q_ad, q_bn, q_bd
);
	logic [2:0] act_q [2];
	logic signed [15:0] an_q [2], ad_q [2], bn_q [2], bd_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	function automatic logic signed [15:0] sx(input logic [15:0] v);
		return 16'(signed'(v[OPERAND_BITS-1:0]));
	endfunction

	assign ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_act = act_q[rd_q];
	assign q_an = an_q[rd_q];
	assign q_ad = ad_q[rd_q];
	assign q_bn = bn_q[rd_q];
	assign q_bd = bd_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (valid && ready) begin
				act_q[wr_q] <= action;
				an_q[wr_q] <= sx(a_num);
				ad_q[wr_q] <= sx(a_den);
				bn_q[wr_q] <= sx(b_num);
				bd_q[wr_q] <= sx(b_den);
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((valid && ready) ? 1 : 0) - 2'((q_pop && q_valid) ? 1 : 0);
		end
	end
endmodule

// File: src/rar_back.sv
// ----------------------------------------------------------------------------
// Back end
// Reduces A (and B), forms products (not for reduce), reduces, holds result.
// ----------------------------------------------------------------------------
module rar_back
	import rar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic [2:0]  q_act,
	input  logic signed [15:0] q_an, q_ad, q_bn, q_bd,
	output logic        valid,
	input  logic        ready,
	output logic signed [32:0] res_num,
	output logic signed [32:0] res_den,
	output logic        zero_den
);
	typedef enum logic [2:0] {B_IDLE, B_RA, B_RB, B_MUL, B_SUM, B_RR, B_OUT} state_t;
	state_t state_q;
	logic [2:0] act_q;
	logic signed [32:0] bn_q, bd_q, an_q, ad_q, p1_q, p2_q, p3_q;
	logic flag_q, gstart, gdone, gz;
	logic signed [32:0] gn, gd, gq_n, gq_d;
	logic is_red;

	// Reduced operands fit in 17 signed bits; the product is formed at full width.
	function automatic logic signed [32:0] smul(input logic signed [16:0] x,
			input logic signed [16:0] y);
		logic signed [33:0] p;
		p = x * y;
		return p[32:0];
	endfunction

	assign is_red = !(act_q == ACT_ADD || act_q == ACT_SUB || act_q == ACT_MUL
		|| act_q == ACT_DIV);
	assign q_pop = (state_q == B_IDLE);

	rar_gcd_div #(.W(33)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gstart), .num(gn), .den(gd),
		.done(gdone), .q_num(gq_n), .q_den(gq_d), .zflag(gz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid <= 1'b0;
			gstart <= 1'b0;
		end else begin
			gstart <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						act_q <= q_act;
						bn_q <= 33'(q_bn);
						bd_q <= 33'(q_bd);
						gn <= 33'(q_an);
						gd <= 33'(q_ad);
						gstart <= 1'b1;
						flag_q <= 1'b0;
						state_q <= B_RA;
					end
				end
				B_RA: if (gdone) begin
					an_q <= gq_n;
					ad_q <= gq_d;
					flag_q <= gz;
					if (is_red) begin
						gn <= gq_n;
						gd <= gq_d;
						state_q <= B_RR;
					end else begin
						gn <= bn_q;
						gd <= bd_q;
						state_q <= B_RB;
					end
					gstart <= 1'b1;
				end
				B_RB: if (gdone) begin
					bn_q <= gq_n;
					bd_q <= gq_d;
					flag_q <= flag_q | gz;
					state_q <= B_MUL;
				end
				B_MUL: begin
					p1_q <= smul(an_q[16:0], bd_q[16:0]);
					case (act_q)
						ACT_MUL: p2_q <= smul(an_q[16:0], bn_q[16:0]);
						ACT_DIV: p2_q <= smul(an_q[16:0], bd_q[16:0]);
						default: p2_q <= smul(bn_q[16:0], ad_q[16:0]);
					endcase
					p3_q <= (act_q == ACT_DIV) ? smul(ad_q[16:0], bn_q[16:0])
						: smul(ad_q[16:0], bd_q[16:0]);
					state_q <= B_SUM;
				end
				B_SUM: begin
					case (act_q)
						ACT_ADD: gn <= p1_q + p2_q;
						ACT_SUB: gn <= p1_q - p2_q;
						default: gn <= p2_q;
					endcase
					gd <= p3_q;
					gstart <= 1'b1;
					state_q <= B_RR;
				end
				B_RR: if (gdone) begin
					res_num <= gq_n;
					res_den <= gq_d;
					zero_den <= flag_q | gz;
					valid <= 1'b1;
					state_q <= B_OUT;
				end
				B_OUT: if (ready) begin
					valid <= 1'b0;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// File: src/rational_arith_reduce_unit.sv
// Timing: each item runs through the GCD remainder loop, one remainder pass per
// Euclid step, and two divisions in each reduction (two reductions for reduce,
// three otherwise).
// Throughput: one item at a time in the back end; the front queue holds two more.
// Reset: arst_n clears the queue and all control state asynchronously.
// ----------------------------------------------------------------------------
// Rational arithmetic unit with GCD reduction (top level)
// ----------------------------------------------------------------------------
`include "rational_arith_reduce_unit_macros.svh"
module rational_arith_reduce_unit
	import rar_pkg::*;
#(
	parameter int OPERAND_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic signed [15:0] a_num,
	input  logic signed [15:0] a_den,
	input  logic signed [15:0] b_num,
	input  logic signed [15:0] b_den,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [32:0] res_num,
	output logic signed [32:0] res_den,
	output logic        zero_den
);
	logic qv, qp;
	logic [2:0] qa;
	logic signed [15:0] qan, qad, qbn, qbd;

	rar_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.q_valid(qv), .q_pop(qp), .q_act(qa), .q_an(qan), .q_ad(qad),
		.q_bn(qbn), .q_bd(qbd)
	);

	rar_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_pop(qp), .q_act(qa),
		.q_an(qan), .q_ad(qad), .q_bn(qbn), .q_bd(qbd), .valid(out_valid),
		.ready(out_ready), .res_num(res_num), .res_den(res_den), .zero_den(zero_den)
	);

	`RAR_ASSERT_IMP(a_den_nz, clk, arst_n, out_valid, res_den != '0)
	`RAR_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the rational arithmetic unit
// Drives fraction pairs and actions through the valid/ready input channel,
// predicts each reduced result in the bench, and compares every output
// transfer field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rar_pkg::*;

	typedef struct packed {
		logic signed [32:0] num;
		logic signed [32:0] den;
		logic               zflag;
	} fraction_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = ACT_ADD;
	logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [32:0] res_num, res_den;
	logic zero_den;

	fraction_result_t pending_results[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always #5 clk = ~clk;

	rational_arith_reduce_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .zero_den(zero_den)
	);

	function automatic longint gcd_mag(longint x, longint y);
		longint r;
		if (x < 0) x = -x;
		if (y < 0) y = -y;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// A zero denominator becomes 1 and raises the flag before the GCD division.
	function automatic void reduce_fraction(inout longint n, inout longint d, inout bit zf);
		longint g;
		if (d == 0) begin
			d = 1;
			zf = 1'b1;
		end
		g = gcd_mag(n, d);
		if (g == 0) g = 1;
		n = n / g;
		d = d / g;
	endfunction

	function automatic fraction_result_t predict_fraction(logic [2:0] act,
			logic signed [15:0] an_i, logic signed [15:0] ad_i,
			logic signed [15:0] bn_i, logic signed [15:0] bd_i);
		longint an, ad, bn, bd, rn, rd;
		bit zf;
		fraction_result_t r;
		an = an_i; ad = ad_i; bn = bn_i; bd = bd_i; zf = 1'b0;
		reduce_fraction(an, ad, zf);
		if (act <= ACT_DIV) reduce_fraction(bn, bd, zf);
		case (act)
			ACT_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
			ACT_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
			ACT_MUL: begin rn = an * bn; rd = ad * bd; end
			ACT_DIV: begin rn = an * bd; rd = ad * bn; end
			default: begin rn = an; rd = ad; end
		endcase
		reduce_fraction(rn, rd, zf);
		r.num = rn[32:0];
		r.den = rd[32:0];
		r.zflag = zf;
		return r;
	endfunction

	// Valid stays high between back-to-back items and drops only while idling.
	task automatic send_fraction(logic [2:0] act, logic signed [15:0] an,
			logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(predict_fraction(act, an, ad, bn, bd));
		@(negedge clk);
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		fraction_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no prediction waiting");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (res_num !== e.num) begin
					$error("res_num expected %0d actual %0d", e.num, res_num);
					fail_count++;
				end
				if (res_den !== e.den) begin
					$error("res_den expected %0d actual %0d", e.den, res_den);
					fail_count++;
				end
				if (zero_den !== e.zflag) begin
					$error("zero_den expected %0d actual %0d", e.zflag, zero_den);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [15:0] rand_operand();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(signed'($urandom_range(8)) - 4);
			3: return 16'($urandom_range(60) * ($urandom_range(1) ? 1 : -1));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [2:0] act;
		for (int i = 0; i <= 7; i++) begin
			act = 3'(i);
			send_fraction(act, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		end
		send_fraction(ACT_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd2);
		send_fraction(ACT_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd9);
		send_fraction(ACT_MUL, 16'sd0, -16'sd6, 16'sd4, 16'sd8);
		send_fraction(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
		send_fraction(ACT_RED, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_fraction(ACT_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_fraction(ACT_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0);
		send_fraction(ACT_MUL, 16'sh7fff, 16'sd1, 16'sh7fff, 16'sd1);
		send_fraction(ACT_RED, 16'sd12, -16'sd18, 16'sh7fff, 16'sh8000);
		// Hold off until the unit has emptied completely.
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_fraction(3'($urandom_range(7)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		send_idle_pct = 17; recv_idle_pct = 52;
		test_random(280);
		send_idle_pct = 52; recv_idle_pct = 17;
		test_random(280);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(290);
		wait_drained();
		repeat (1000) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("** rational_arith_reduce_unit: PASSED **");
		else
			$display("** rational_arith_reduce_unit: FAILED **");
		$finish;
	end

	initial begin
		#200ms;
		$display("** rational_arith_reduce_unit: FAILED **");
		$finish;
	end
endmodule
